// ----- hdl/ndaas_pkg.sv -----
package ndaas_pkg;

  localparam int MAX_DIMS_DEF  = 4;
  localparam int MEM_DEPTH_DEF = 1024;

  localparam int DIM_SLOTS   = 4;
  localparam int DCNT_W      = 3;
  localparam int EXT_W       = 11;
  localparam int IDX_W       = 10;
  localparam int DATA_W      = 32;
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 32;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [0:0] {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_BADCFG = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_DIM_COUNT = 3'd0,
    REG_EXTENT_0  = 3'd1,
    REG_EXTENT_1  = 3'd2,
    REG_EXTENT_2  = 3'd3,
    REG_EXTENT_3  = 3'd4
  } reg_idx_t;

  // configuration as seen by the request front end
  typedef struct packed {
    logic [DCNT_W-1:0]                dim_count;
    logic [DIM_SLOTS-1:0][EXT_W-1:0]  extent;
    logic                             bad;
    logic                             busy;
  } cfg_view_t;

  typedef struct packed {
    op_t     op;
    status_t status;
  } req_ctl_t;

endpackage

// ----- hdl/ndaas_fifo.sv -----
module ndaas_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = ndaas_pkg::QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [W-1:0]     wr_data,
  input  logic             rd_en,
  output logic [W-1:0]     rd_data,
  output logic             full,
  output logic             empty,
  output logic [CNT_W-1:0] count
);

  logic [W-1:0]     slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = slot_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- hdl/ndaas_cfg.sv -----
module ndaas_cfg #(
  parameter int MAX_DIMS  = ndaas_pkg::MAX_DIMS_DEF,
  parameter int MEM_DEPTH = ndaas_pkg::MEM_DEPTH_DEF,
  localparam int STRIDE_W = $clog2(MEM_DEPTH + 1),
  localparam int K_W      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
  localparam int MUL_W    = STRIDE_W + ndaas_pkg::EXT_W
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ndaas_pkg::CFG_AW-1:0]      paddr,
  input  logic [ndaas_pkg::CFG_DW-1:0]      pwdata,
  output logic [ndaas_pkg::CFG_DW-1:0]      prdata,
  output logic                              pready,
  output ndaas_pkg::cfg_view_t              cfg_o,
  output logic [MAX_DIMS-1:0][STRIDE_W-1:0] stride_o
);

  logic [ndaas_pkg::DCNT_W-1:0]                           dim_count_r, dim_count_nxt;
  logic [ndaas_pkg::DIM_SLOTS-1:0][ndaas_pkg::EXT_W-1:0]  extent_r, extent_nxt;
  logic [MAX_DIMS-1:0][STRIDE_W-1:0]                      stride_r;
  logic                                                   busy_r;
  logic                                                   bad_r;
  logic                                                   work_bad_r, step_bad;
  logic [STRIDE_W-1:0]                                    prod_r, prod_nxt;
  logic [K_W-1:0]                                         k_r;
  logic [ndaas_pkg::EXT_W-1:0]                            ext_lane [MAX_DIMS];
  logic [ndaas_pkg::EXT_W-1:0]                            ext_k;
  logic [MUL_W-1:0]                                       mul;
  logic                                                   used_k;
  logic                                                   wr;
  ndaas_pkg::reg_idx_t                                    reg_idx;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_idx = ndaas_pkg::reg_idx_t'(paddr[4:2]);

  always_comb begin
    dim_count_nxt = dim_count_r;
    extent_nxt    = extent_r;
    case (reg_idx)
      ndaas_pkg::REG_DIM_COUNT: dim_count_nxt = pwdata[ndaas_pkg::DCNT_W-1:0];
      ndaas_pkg::REG_EXTENT_0:  extent_nxt[0] = pwdata[ndaas_pkg::EXT_W-1:0];
      ndaas_pkg::REG_EXTENT_1:  extent_nxt[1] = pwdata[ndaas_pkg::EXT_W-1:0];
      ndaas_pkg::REG_EXTENT_2:  extent_nxt[2] = pwdata[ndaas_pkg::EXT_W-1:0];
      ndaas_pkg::REG_EXTENT_3:  extent_nxt[3] = pwdata[ndaas_pkg::EXT_W-1:0];
      default: ;
    endcase
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      ndaas_pkg::REG_DIM_COUNT: prdata = ndaas_pkg::CFG_DW'(dim_count_r);
      ndaas_pkg::REG_EXTENT_0:  prdata = ndaas_pkg::CFG_DW'(extent_r[0]);
      ndaas_pkg::REG_EXTENT_1:  prdata = ndaas_pkg::CFG_DW'(extent_r[1]);
      ndaas_pkg::REG_EXTENT_2:  prdata = ndaas_pkg::CFG_DW'(extent_r[2]);
      ndaas_pkg::REG_EXTENT_3:  prdata = ndaas_pkg::CFG_DW'(extent_r[3]);
      default:                  prdata = '0;
    endcase
  end

  // stride sequencer: one dimension per cycle, running product of extents
  always_comb begin
    for (int k = 0; k < MAX_DIMS; k++) begin
      ext_lane[k] = extent_r[k];
    end
    ext_k    = ext_lane[k_r];
    used_k   = (ndaas_pkg::DCNT_W'(k_r) < dim_count_r);
    mul      = MUL_W'(prod_r) * MUL_W'(ext_k);
    step_bad = work_bad_r;
    prod_nxt = prod_r;
    if (!work_bad_r && used_k) begin
      if (ext_k == '0 || mul > MUL_W'(MEM_DEPTH)) begin
        step_bad = 1'b1;
      end
      prod_nxt = mul[STRIDE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_count_r <= ndaas_pkg::DCNT_W'(1);
      for (int k = 0; k < ndaas_pkg::DIM_SLOTS; k++) begin
        extent_r[k] <= ndaas_pkg::EXT_W'(1);
      end
      for (int k = 0; k < MAX_DIMS; k++) begin
        stride_r[k] <= STRIDE_W'(1);
      end
      busy_r     <= 1'b0;
      bad_r      <= 1'b0;
      work_bad_r <= 1'b0;
      prod_r     <= STRIDE_W'(1);
      k_r        <= '0;
    end else if (wr) begin
      dim_count_r <= dim_count_nxt;
      extent_r    <= extent_nxt;
      busy_r      <= 1'b1;
      k_r         <= '0;
      prod_r      <= STRIDE_W'(1);
      work_bad_r  <= (dim_count_nxt == '0) ||
                     (dim_count_nxt > ndaas_pkg::DCNT_W'(MAX_DIMS));
    end else if (busy_r) begin
      stride_r[k_r] <= prod_r;
      prod_r        <= prod_nxt;
      work_bad_r    <= step_bad;
      if (k_r == K_W'(MAX_DIMS - 1)) begin
        busy_r <= 1'b0;
        bad_r  <= step_bad;
      end else begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  assign cfg_o.dim_count = dim_count_r;
  assign cfg_o.extent    = extent_r;
  assign cfg_o.bad       = bad_r;
  assign cfg_o.busy      = busy_r;
  assign stride_o        = stride_r;

endmodule

// ----- hdl/ndaas_front.sv -----
module ndaas_front #(
  parameter int MAX_DIMS  = ndaas_pkg::MAX_DIMS_DEF,
  parameter int MEM_DEPTH = ndaas_pkg::MEM_DEPTH_DEF,
  localparam int STRIDE_W = $clog2(MEM_DEPTH + 1),
  localparam int ADDR_W   = $clog2(MEM_DEPTH),
  localparam int PROD_W   = STRIDE_W + ndaas_pkg::IDX_W,
  localparam int SUM_W    = PROD_W + 2
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   push,
  output logic                                                   full,
  input  ndaas_pkg::op_t                                         op_i,
  input  logic [ndaas_pkg::DIM_SLOTS-1:0][ndaas_pkg::IDX_W-1:0]  index_i,
  input  logic [ndaas_pkg::DATA_W-1:0]                           wdata_i,
  input  ndaas_pkg::cfg_view_t                                   cfg_i,
  input  logic [MAX_DIMS-1:0][STRIDE_W-1:0]                      stride_i,
  input  logic                                                   q_full_i,
  output logic                                                   q_push_o,
  output ndaas_pkg::req_ctl_t                                    q_ctl_o,
  output logic [ADDR_W-1:0]                                      q_addr_o,
  output logic [ndaas_pkg::DATA_W-1:0]                           q_wdata_o
);

  logic                         v_r;
  ndaas_pkg::op_t               op_r;
  logic [ndaas_pkg::DATA_W-1:0] wdata_r;
  logic [PROD_W-1:0]            prod_r [MAX_DIMS];
  logic [PROD_W-1:0]            prod_c [MAX_DIMS];
  logic                         oor_r, oor_c;
  logic                         bad_r;
  logic                         used;
  logic                         accept;
  logic [SUM_W-1:0]             sum;
  logic                         over;

  assign full     = cfg_i.busy || (v_r && q_full_i);
  assign accept   = push && !full;
  assign q_push_o = v_r && !q_full_i;

  // per-dimension index times stride, and range check against the extent
  always_comb begin
    oor_c = 1'b0;
    used  = 1'b0;
    for (int k = 0; k < MAX_DIMS; k++) begin
      used      = (ndaas_pkg::DCNT_W'(k) < cfg_i.dim_count);
      prod_c[k] = used ? PROD_W'(index_i[k]) * PROD_W'(stride_i[k]) : '0;
      if (used && ({1'b0, index_i[k]} >= cfg_i.extent[k])) begin
        oor_c = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (accept) begin
      v_r <= 1'b1;
    end else if (q_push_o) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= op_i;
      wdata_r <= wdata_i;
      oor_r   <= oor_c;
      bad_r   <= cfg_i.bad;
      for (int k = 0; k < MAX_DIMS; k++) begin
        prod_r[k] <= prod_c[k];
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < MAX_DIMS; k++) begin
      sum = sum + SUM_W'(prod_r[k]);
    end
    over = (sum >= SUM_W'(MEM_DEPTH));
  end

  always_comb begin
    q_ctl_o.op = op_r;
    if (bad_r) begin
      q_ctl_o.status = ndaas_pkg::ST_BADCFG;
    end else if (oor_r || over) begin
      q_ctl_o.status = ndaas_pkg::ST_RANGE;
    end else begin
      q_ctl_o.status = ndaas_pkg::ST_OK;
    end
  end

  assign q_addr_o  = sum[ADDR_W-1:0];
  assign q_wdata_o = wdata_r;

endmodule

// ----- hdl/ndaas_back.sv -----
module ndaas_back #(
  parameter int MEM_DEPTH = ndaas_pkg::MEM_DEPTH_DEF,
  localparam int ADDR_W   = $clog2(MEM_DEPTH),
  localparam int OUT_W    = $bits(ndaas_pkg::status_t) + ndaas_pkg::DATA_W,
  localparam int CNT_W    = $clog2(ndaas_pkg::QUEUE_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty_i,
  input  ndaas_pkg::req_ctl_t          q_ctl_i,
  input  logic [ADDR_W-1:0]            q_addr_i,
  input  logic [ndaas_pkg::DATA_W-1:0] q_wdata_i,
  output logic                         q_pop_o,
  output logic                         empty,
  input  logic                         pop,
  output logic [ndaas_pkg::DATA_W-1:0] read_data_o,
  output ndaas_pkg::status_t           status_o
);

  logic [ndaas_pkg::DATA_W-1:0] mem [MEM_DEPTH];
  logic [ndaas_pkg::DATA_W-1:0] rd_r;
  ndaas_pkg::req_ctl_t          ctl_r;
  logic                         mem_v_r;
  logic [CNT_W-1:0]             out_count;
  logic [CNT_W:0]               pending;
  logic                         issue;
  logic [ndaas_pkg::DATA_W-1:0] res_data;
  logic [OUT_W-1:0]             out_wr, out_rd;
  logic                         out_full;

  // results in the output queue plus the one in the memory stage
  assign pending = {1'b0, out_count} + (CNT_W + 1)'(mem_v_r);
  assign issue   = !q_empty_i && (pending < (CNT_W + 1)'(ndaas_pkg::QUEUE_DEPTH));
  assign q_pop_o = issue;

  always_ff @(posedge clk) begin
    if (issue && q_ctl_i.status == ndaas_pkg::ST_OK && q_ctl_i.op == ndaas_pkg::OP_WRITE) begin
      mem[q_addr_i] <= q_wdata_i;
    end
    if (issue) begin
      rd_r  <= mem[q_addr_i];
      ctl_r <= q_ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_v_r <= 1'b0;
    end else begin
      mem_v_r <= issue;
    end
  end

  assign res_data = (ctl_r.status == ndaas_pkg::ST_OK && ctl_r.op == ndaas_pkg::OP_READ) ?
                    rd_r : '0;
  assign out_wr   = {ctl_r.status, res_data};

  ndaas_fifo #(
    .W     (OUT_W),
    .DEPTH (ndaas_pkg::QUEUE_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_v_r),
    .wr_data (out_wr),
    .rd_en   (pop),
    .rd_data (out_rd),
    .full    (out_full),
    .empty   (empty),
    .count   (out_count)
  );

  // credit check keeps the queue from filling past what it can take
  assign read_data_o = out_full ? out_rd[ndaas_pkg::DATA_W-1:0] : out_rd[ndaas_pkg::DATA_W-1:0];
  assign status_o    = ndaas_pkg::status_t'(out_rd[OUT_W-1:ndaas_pkg::DATA_W]);

endmodule

// ----- hdl/ndim_array_address_store_core.sv -----
// N-dimensional array store over one element memory.
// Config: APB-style port, registers dim_count at 0x00 and extent_0..extent_3
//   at 0x04..0x10 (extent_0 varies fastest). Every write starts a stride
//   recompute that walks one dimension per cycle; full stays high meanwhile.
// Input: a request (op, index_0..3, write_data) is taken on push while full
//   is low. Output: one result (read_data, status) per request, oldest first,
//   presented while empty is low and taken on pop.
// Status: ok, index out of range, or bad configuration (dim_count zero or
//   above MAX_DIMS, zero extent, or extent product above MEM_DEPTH).
//   read_data is zero except on a good read.
// Path: the accepting edge loads the front register; the request then moves
//   through the request queue and the memory read into the result queue,
//   from which it is popped.
// Throughput: one request per cycle while full is low (single memory port).
// A stalled receiver fills the result queue, then the request queue, then
//   full rises; nothing is dropped. Reset gives dim_count 1, extents 1, empty
//   queues. Memory content is not reset; read only written elements.
module ndim_array_address_store_core #(
  parameter int MAX_DIMS  = ndaas_pkg::MAX_DIMS_DEF,
  parameter int MEM_DEPTH = ndaas_pkg::MEM_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ndaas_pkg::CFG_AW-1:0]        paddr,
  input  logic [ndaas_pkg::CFG_DW-1:0]        pwdata,
  output logic [ndaas_pkg::CFG_DW-1:0]        prdata,
  output logic                                pready,
  input  logic                                push,
  output logic                                full,
  input  logic                                in_op,
  input  logic [ndaas_pkg::IDX_W-1:0]         in_index_0,
  input  logic [ndaas_pkg::IDX_W-1:0]         in_index_1,
  input  logic [ndaas_pkg::IDX_W-1:0]         in_index_2,
  input  logic [ndaas_pkg::IDX_W-1:0]         in_index_3,
  input  logic signed [ndaas_pkg::DATA_W-1:0] in_write_data,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [ndaas_pkg::DATA_W-1:0] out_read_data,
  output logic [1:0]                          out_status
);

  localparam int STRIDE_W = $clog2(MEM_DEPTH + 1);
  localparam int ADDR_W   = $clog2(MEM_DEPTH);
  localparam int REQ_W    = $bits(ndaas_pkg::req_ctl_t) + ADDR_W + ndaas_pkg::DATA_W;

  ndaas_pkg::cfg_view_t                                   cfg_view;
  logic [MAX_DIMS-1:0][STRIDE_W-1:0]                      stride;
  logic [ndaas_pkg::DIM_SLOTS-1:0][ndaas_pkg::IDX_W-1:0]  index_vec;
  logic                                                   q_full, q_empty, q_push, q_pop;
  ndaas_pkg::req_ctl_t                                    f_ctl, b_ctl;
  logic [ADDR_W-1:0]                                      f_addr, b_addr;
  logic [ndaas_pkg::DATA_W-1:0]                           f_wdata, b_wdata;
  logic [REQ_W-1:0]                                       q_wr, q_rd;
  logic [ndaas_pkg::DATA_W-1:0]                           rdata;
  ndaas_pkg::status_t                                     status;

  assign index_vec = {in_index_3, in_index_2, in_index_1, in_index_0};

  ndaas_cfg #(
    .MAX_DIMS  (MAX_DIMS),
    .MEM_DEPTH (MEM_DEPTH)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg_o    (cfg_view),
    .stride_o (stride)
  );

  ndaas_front #(
    .MAX_DIMS  (MAX_DIMS),
    .MEM_DEPTH (MEM_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .op_i      (ndaas_pkg::op_t'(in_op)),
    .index_i   (index_vec),
    .wdata_i   (in_write_data),
    .cfg_i     (cfg_view),
    .stride_i  (stride),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_ctl_o   (f_ctl),
    .q_addr_o  (f_addr),
    .q_wdata_o (f_wdata)
  );

  assign q_wr = {f_ctl, f_addr, f_wdata};

  ndaas_fifo #(
    .W     (REQ_W),
    .DEPTH (ndaas_pkg::QUEUE_DEPTH)
  ) u_req_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty),
    .count   ()
  );

  assign {b_ctl, b_addr, b_wdata} = q_rd;

  ndaas_back #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty_i   (q_empty),
    .q_ctl_i     (b_ctl),
    .q_addr_i    (b_addr),
    .q_wdata_i   (b_wdata),
    .q_pop_o     (q_pop),
    .empty       (empty),
    .pop         (pop),
    .read_data_o (rdata),
    .status_o    (status)
  );

  assign out_read_data = rdata;
  assign out_status    = status;

endmodule
